FILE: design/assert_macros.svh
// Assertion macros used by the radix digit converter RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RDC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define RDC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rdc_pkg.sv
// Shared constants, types and helper functions for the radix digit converter.
// No dependencies; imported by rdc_div_serial and radix_digit_converter.
package rdc_pkg;

    // Value and digit store sizing
    localparam int VALUE_BITS  = 31;
    localparam int DIGIT_SLOTS = 32;
    localparam int SLOT_W      = $clog2(DIGIT_SLOTS);
    localparam int COUNT_W     = $clog2(DIGIT_SLOTS + 1);
    localparam int STEP_W      = $clog2(VALUE_BITS + 1);
    localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;

    // Field widths
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;
    localparam int OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;

    // Radix limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(8'h41);
    localparam logic [CHAR_W-1:0] CHAR_F    = CHAR_W'(8'h46);
    localparam logic [CHAR_W-1:0] CHAR_NINE = CHAR_W'(8'h39);

    // Divider status toward the controller
    typedef struct packed {
        logic done;     // one-cycle pulse: quotient and remainder valid
        logic nonzero;  // quotient of the finished division is not zero
    } div_status_t;

    // Force the radix into the legal range 2..16
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN)
            return RADIX_MIN;
        else if (r > RADIX_MAX)
            return RADIX_MAX;
        else
            return r;
    endfunction

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        if (d < DIGIT_W'(10))
            return CHAR_ZERO + CHAR_W'(d);
        else
            return CHAR_A + CHAR_W'(d) - CHAR_W'(10);
    endfunction

endpackage

FILE: design/rdc_div_serial.sv
// Bit-serial restoring divider: one quotient bit per clock, VALUE_BITS steps.
// Depends on rdc_pkg for widths and the status struct.
module rdc_div_serial
    import rdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]    divisor,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [DIGIT_W-1:0]    remainder,
    output div_status_t           status
);

    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  nz_reg, nz_next;
    logic [RADIX_W-1:0]    trial;
    logic                  qbit;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, q_reg[VALUE_BITS-1]};
    assign qbit  = (trial >= divisor);

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        nz_next   = nz_reg;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            step_next = STEP_W'(VALUE_BITS);
            busy_next = 1'b1;
            nz_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            q_next    = {q_reg[VALUE_BITS-2:0], qbit};
            rem_next  = qbit ? DIGIT_W'(trial - divisor) : DIGIT_W'(trial);
            nz_next   = nz_reg | qbit;
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            nz_reg   <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            nz_reg   <= nz_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign quotient       = q_reg;
    assign remainder      = rem_reg;
    assign status.done    = done_reg;
    assign status.nonzero = nz_reg;

endmodule

FILE: design/radix_digit_converter.sv
// Radix digit converter top level: control, digit store and stream ports.
// Depends on rdc_pkg, rdc_div_serial and assert_macros.svh.
//
// Usage:
//   Write the radix (2..16, values outside are clamped, reset 10) through
//   cfg_we/cfg_wdata while the block is idle.
//   Present a number on s_tdata[30:0] with s_tvalid. s_tready is high only
//   while the block is idle; one number is converted at a time.
//   The digits leave on m_tdata[6:0] as ASCII '0'-'9' and 'A'-'F', most
//   significant first; m_tlast marks the least significant digit. An input
//   of zero gives the single digit '0'.
// Sequence:
//   Each digit comes from the bit-serial divider, least significant first,
//   into the store; then each digit is read from the store and presented,
//   most significant first.
// Reset:
//   rst_n clears control state and sets the radix to 10; the store is not
//   cleared, every digit is written before it is read.
// Stall:
//   A digit holds on m_tdata/m_tlast while m_tready is low; nothing advances.
module radix_digit_converter
    import rdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration
    input  logic                   cfg_we,
    input  logic [RADIX_W-1:0]     cfg_wdata,      // radix
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,        // [30:0] number_in, rest zero
    // Output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,        // [6:0] digit_char, [7] zero
    output logic                   m_tlast         // last_digit
);

`include "assert_macros.svh"

    // Controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_SHOW = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [RADIX_W-1:0]    radix_reg;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    count_inc;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [DIGIT_W-1:0]    digit_store [DIGIT_SLOTS];
    logic [DIGIT_W-1:0]    rd_digit_reg;
    logic                  in_xfer, out_xfer;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DIGIT_W-1:0]    div_remainder;
    div_status_t           div_stat;
    logic                  store_we;
    logic                  conv_end;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;
    assign count_inc = count_reg + 1'b1;
    assign store_we  = (state_reg == ST_DIV) && div_stat.done;
    assign conv_end  = !div_stat.nonzero || (count_inc == COUNT_W'(DIGIT_SLOTS));

    // Hold the clamped radix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg_we)
            radix_reg <= clamp_radix(cfg_wdata);
    end

    // Start a division on a new number or on the previous quotient
    assign div_start    = in_xfer || (store_we && !conv_end);
    assign div_dividend = in_xfer ? s_tdata[VALUE_BITS-1:0] : div_quotient;

    rdc_div_serial u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_reg),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .status    (div_stat)
    );

    // Sequence: divide out digits, then read them back most significant first
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    count_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    count_next = count_inc;
                    if (conv_end)
                    begin
                        slot_next  = count_reg[SLOT_W-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_xfer)
                begin
                    if (slot_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        slot_next  = slot_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
        end
    end

    // Digit store: write each remainder, registered read for the output
    always_ff @(posedge clk)
    begin
        if (store_we)
            digit_store[count_reg[SLOT_W-1:0]] <= div_remainder;
        if (state_reg == ST_READ)
            rd_digit_reg <= digit_store[slot_reg];
    end

    // Stream outputs
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SHOW);
    assign m_tdata  = OUT_TDATA_W'(ascii_of(rd_digit_reg));
    assign m_tlast  = (slot_reg == '0);

    // Checks
    `RDC_ASSERT_IMP(a_one_side, s_tready, !m_tvalid, "input taken while a digit is shown")
    `RDC_ASSERT_IMP(a_done_in_div, div_stat.done, state_reg == ST_DIV,
                    "divider finished outside the divide phase")
    `RDC_ASSERT_NXT(a_last_frees, out_xfer && m_tlast, s_tready,
                    "block not idle after the last digit")
    `RDC_ASSERT_IMP(a_char_range, m_tvalid,
                    (m_tdata[6:0] >= CHAR_ZERO && m_tdata[6:0] <= CHAR_NINE) ||
                    (m_tdata[6:0] >= CHAR_A && m_tdata[6:0] <= CHAR_F),
                    "digit character out of range")

endmodule
